// ----- sv/fps_pkg.sv -----
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants, mode codes and the node RAM request type for the
// prefix-sum tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  // Store geometry
  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  // Counts run 0..DEPTH, so one bit more than the address
  localparam int IDX_W      = ADDR_W + 1;
  localparam int MODE_W     = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PFX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

  // One write port and one read port per cycle
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- sv/fps_ram.sv -----
// ----------------------------------------------------------------------------
// fps_ram
// Tree node store: one synchronous write and one synchronous read per cycle,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_ram (
  input  wire                              clk,
  input  wire fps_pkg::ram_req_t           req,
  output logic [fps_pkg::VALUE_BITS-1:0]   rdata
);
  import fps_pkg::*;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/fenwick_prefix_sum_search.sv -----
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_search
// Binary indexed tree over a 1024-node RAM: point add, prefix sum and
// search by target sum using binary lifting.
//
//  Channel  | Ports                                     | Handshake
//  ---------+-------------------------------------------+--------------------
//  input    | in_mode, in_position, in_amount           | start & !busy
//  result   | out_found_index, out_result_value         | out_valid, 1 cycle
//  config   | cfg_wdata (size in use)                   | cfg_we
//
//  Each tree step is one RAM read; the walk is serialized on the read port.
//  Add: one read-modify-write per covering node (up to 11). Prefix: one read per
//  set bit of the count. Search: prefix of the size, then one read per lifting
//  bit whose candidate lies inside the size. Mode 3 starts nothing.
//  After reset a clearing pass zeroes all 1024 RAM entries with busy high.
//  Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_prefix_sum_search (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [fps_pkg::MODE_W-1:0]         in_mode,
  input  wire  [fps_pkg::IDX_W-1:0]          in_position,
  input  wire  [fps_pkg::VALUE_BITS-1:0]     in_amount,
  input  wire                                cfg_we,
  input  wire  [fps_pkg::IDX_W-1:0]          cfg_wdata,
  output logic                               out_valid,
  output logic [fps_pkg::IDX_W-1:0]          out_found_index,
  output logic [fps_pkg::VALUE_BITS-1:0]     out_result_value
);
  import fps_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_PFX,
    ST_LIFT_ISSUE,
    ST_LIFT_EVAL
  } state_t;

  state_t                state_r,   state_nxt;
  logic [ADDR_W-1:0]     clr_r,     clr_nxt;
  logic [IDX_W:0]        j_r,       j_nxt;
  logic [VALUE_BITS-1:0] acc_r,     acc_nxt;
  logic [VALUE_BITS-1:0] amt_r,     amt_nxt;
  logic [IDX_W-1:0]      idx_r,     idx_nxt;
  logic [IDX_W-1:0]      step_r,    step_nxt;
  logic                  srch_r,    srch_nxt;
  logic [IDX_W-1:0]      size_r;
  logic                  ovld_r,    ovld_nxt;
  logic [IDX_W-1:0]      ofound_r,  ofound_nxt;
  logic [VALUE_BITS-1:0] oval_r,    oval_nxt;

  ram_req_t              req;
  logic [VALUE_BITS-1:0] rdata;

  // Derived values
  logic [IDX_W-1:0]      n_eff;
  logic [IDX_W-1:0]      walk_cnt;
  logic [IDX_W-1:0]      walk_cm1;
  logic [IDX_W:0]        j_m1;
  logic [IDX_W:0]        j_up;
  logic [IDX_W-1:0]      cand;
  logic [IDX_W-1:0]      cand_m1;
  logic [VALUE_BITS-1:0] sum;
  logic [IDX_W-1:0]      top_step;

  fps_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Highest power of two not above a count
  function automatic logic [IDX_W-1:0] msb_isolate(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (v[i]) r = IDX_W'(1) << i;
    end
    return r;
  endfunction

  assign n_eff    = (size_r > IDX_W'(DEPTH)) ? IDX_W'(DEPTH) : size_r;
  assign walk_cnt = (in_mode == MODE_SRCH) ? n_eff :
                    ((in_position > n_eff) ? n_eff : in_position);
  assign walk_cm1 = walk_cnt - IDX_W'(1);
  assign j_m1     = j_r - (IDX_W+1)'(1);
  assign j_up     = j_r + (j_r & (~j_r + (IDX_W+1)'(1)));
  assign cand     = idx_r | step_r;
  assign cand_m1  = cand - IDX_W'(1);
  assign sum      = acc_r + rdata;
  assign top_step = msb_isolate(n_eff);

  // Next-state logic
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    j_nxt      = j_r;
    acc_nxt    = acc_r;
    amt_nxt    = amt_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    srch_nxt   = srch_r;
    ovld_nxt   = 1'b0;
    ofound_nxt = ofound_r;
    oval_nxt   = oval_r;
    req        = '0;

    unique case (state_r)
      // Zero the node store, one entry per cycle
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
        req.wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (start) begin
          unique case (in_mode) inside
            MODE_ADD: begin
              if (in_position < n_eff) begin
                req.re    = 1'b1;
                req.raddr = in_position[ADDR_W-1:0];
                j_nxt     = {1'b0, in_position} + (IDX_W+1)'(1);
                amt_nxt   = in_amount;
                state_nxt = ST_ADD;
              end
            end
            MODE_PFX, MODE_SRCH: begin
              srch_nxt = (in_mode == MODE_SRCH);
              amt_nxt  = in_amount;
              step_nxt = top_step;
              idx_nxt  = '0;
              acc_nxt  = '0;
              if (walk_cnt == '0) begin
                // Empty count: prefix is zero, empty tree search gives (0,0)
                ovld_nxt   = 1'b1;
                ofound_nxt = '0;
                oval_nxt   = '0;
              end else begin
                req.re    = 1'b1;
                req.raddr = walk_cm1[ADDR_W-1:0];
                j_nxt     = {1'b0, walk_cnt & walk_cm1};
                state_nxt = ST_PFX;
              end
            end
            default: ;
          endcase
        end
      end

      // Update one covering node, fetch the next
      ST_ADD: begin
        req.we    = 1'b1;
        req.waddr = j_m1[ADDR_W-1:0];
        req.wdata = rdata + amt_r;
        if (j_up > (IDX_W+1)'(DEPTH)) begin
          state_nxt = ST_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = ADDR_W'(j_up - (IDX_W+1)'(1));
          j_nxt     = j_up;
        end
      end

      // Accumulate prefix nodes, dropping the low bit each step
      ST_PFX: begin
        acc_nxt = sum;
        if (j_r == '0) begin
          if (!srch_r) begin
            ovld_nxt   = 1'b1;
            ofound_nxt = '0;
            oval_nxt   = sum;
            state_nxt  = ST_IDLE;
          end else if (sum < amt_r) begin
            // Target above total
            ovld_nxt   = 1'b1;
            ofound_nxt = n_eff;
            oval_nxt   = amt_r - sum;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_LIFT_ISSUE;
          end
        end else begin
          req.re    = 1'b1;
          req.raddr = j_m1[ADDR_W-1:0];
          j_nxt     = j_r & j_m1;
        end
      end

      // Binary lifting: fetch candidate node if inside the size, else halve the step; finish at step zero
      ST_LIFT_ISSUE: begin
        if (step_r == '0) begin
          ovld_nxt   = 1'b1;
          ofound_nxt = idx_r;
          oval_nxt   = amt_r;
          state_nxt  = ST_IDLE;
        end else if (cand <= n_eff) begin
          req.re    = 1'b1;
          req.raddr = cand_m1[ADDR_W-1:0];
          state_nxt = ST_LIFT_EVAL;
        end else begin
          step_nxt = step_r >> 1;
        end
      end

      ST_LIFT_EVAL: begin
        if (rdata < amt_r) begin
          idx_nxt = cand;
          amt_nxt = amt_r - rdata;
        end
        step_nxt  = step_r >> 1;
        state_nxt = ST_LIFT_ISSUE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      size_r  <= '0;
      ovld_r  <= 1'b0;
      srch_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      srch_r  <= srch_nxt;
      ovld_r  <= ovld_nxt;
      if (cfg_we) size_r <= cfg_wdata;
    end
    j_r      <= j_nxt;
    acc_r    <= acc_nxt;
    amt_r    <= amt_nxt;
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    ofound_r <= ofound_nxt;
    oval_r   <= oval_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ovld_r;
  assign out_found_index  = ofound_r;
  assign out_result_value = oval_r;

endmodule

`default_nettype wire

// ----- sv/fps_check.sv -----
// ----------------------------------------------------------------------------
// fps_check
// Port-level checks for the prefix-sum tree block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fps_check (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              start,
  input wire                              busy,
  input wire [fps_pkg::MODE_W-1:0]        in_mode,
  input wire                              out_valid,
  input wire [fps_pkg::IDX_W-1:0]         out_found_index
);
  import fps_pkg::*;

  // Reset is followed by the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  // A result only follows an accepted transaction or work in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a transaction");

  // An add transaction produces no result
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_ADD) |=> !out_valid)
    else $error("result after add");

  // Found index never exceeds the store depth
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found_index <= IDX_W'(DEPTH)))
    else $error("found index out of range");

endmodule

bind fenwick_prefix_sum_search fps_check u_fps_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_found_index (out_found_index)
);

`default_nettype wire
